[rtl/ncomix_pkg.sv]
`default_nettype none

package ncomix_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int MAG_BITS      = SAMPLE_BITS - 1;
    localparam int TDATA_W       = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 32;

    // largest table magnitude, full scale in Q1.(SAMPLE_BITS-1)
    localparam logic [MAG_BITS-1:0] AMP = {MAG_BITS{1'b1}};

    // pi/2 in Q2.30
    localparam logic [63:0] HPI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_PHASE_INC   = 2'd0,
        CFG_START_PHASE = 2'd1,
        CFG_MIX_DIR     = 2'd2
    } t_cfg_reg;

    // quadrant folding for one sine/cosine pair
    typedef struct packed {
        logic sin_max;
        logic sin_neg;
        logic cos_max;
        logic cos_neg;
    } t_fold;

endpackage

`default_nettype wire

[rtl/ncomix_sincos.sv]
`default_nettype none

module ncomix_sincos
    import ncomix_pkg::*;
#(
    parameter int ADDR_BITS = 10
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [ADDR_BITS+1:0]   i_phase_idx,
    output logic      [MAG_BITS-1:0]    o_sin_mag,
    output logic      [MAG_BITS-1:0]    o_cos_mag,
    output t_fold                       o_fold
);

    localparam int DEPTH = 2 ** ADDR_BITS;

    typedef logic [MAG_BITS-1:0] t_rom [DEPTH];

    localparam logic [7:0] TAYLOR_DIV [6] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};

    // quarter-wave sine by integer taylor series in Q2.30
    function automatic logic [MAG_BITS-1:0] sin_entry(input int unsigned k);
        logic        [63:0] x;
        logic        [63:0] x2;
        logic        [63:0] t;
        logic        [63:0] scaled;
        logic signed [63:0] sum;
        x   = (HPI_Q30 * 64'(k) + (64'd1 << (ADDR_BITS - 1))) >> ADDR_BITS;
        x2  = (x * x) >> 30;
        t   = x;
        sum = signed'(x);
        for (int n = 0; n < 6; n++) begin
            t = ((t * x2) >> 30) / 64'(TAYLOR_DIV[n]);
            if (n % 2 == 0) begin
                sum = sum - signed'(t);
            end else begin
                sum = sum + signed'(t);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        scaled = (unsigned'(sum) * 64'(AMP) + (64'd1 << 29)) >> 30;
        return scaled[MAG_BITS-1:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom r;
        for (int k = 0; k < DEPTH; k++) begin
            r[k] = sin_entry(k);
        end
        return r;
    endfunction

    localparam t_rom ROM = build_rom();

    logic [ADDR_BITS-1:0] a;
    logic [1:0]           q;
    logic [ADDR_BITS-1:0] neg_a;
    logic [ADDR_BITS-1:0] sin_addr;
    logic [ADDR_BITS-1:0] cos_addr;
    t_fold                fold;

    logic [MAG_BITS-1:0]  r_sin_mag;
    logic [MAG_BITS-1:0]  r_cos_mag;
    t_fold                r_fold;

    always_comb begin
        a        = i_phase_idx[ADDR_BITS-1:0];
        q        = i_phase_idx[ADDR_BITS+1:ADDR_BITS];
        neg_a    = ADDR_BITS'(~a + 1'b1);
        // odd quadrants run the table backwards; cosine is one quadrant ahead
        sin_addr = q[0] ? neg_a : a;
        cos_addr = q[0] ? a : neg_a;
        fold.sin_max = q[0] && (a == '0);
        fold.cos_max = !q[0] && (a == '0);
        fold.sin_neg = q[1];
        fold.cos_neg = q[1] ^ q[0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin_mag <= ROM[sin_addr];
            r_cos_mag <= ROM[cos_addr];
            r_fold    <= fold;
        end
    end

    assign o_sin_mag = r_sin_mag;
    assign o_cos_mag = r_cos_mag;
    assign o_fold    = r_fold;

endmodule

`default_nettype wire

[rtl/nco_complex_mixer_unit.sv]
// throughput: one item per cycle while the output is not stalled
// path: table read, multiply, then sum/round/saturate, each ending in a register
// a full stage holds while the next one cannot advance; a stalled output backs up the input
// reset: synchronous, active low; clears the phase accumulator, the configuration
// registers and all stage valid flags
`default_nettype none

module nco_complex_mixer_unit
    import ncomix_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // config write port
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    // input stream
    input  wire logic                     i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  wire logic [TDATA_W-1:0]       i_s_axis_tdata,  // sample_i, sample_q
    input  wire logic [0:0]               i_s_axis_tuser,  // restart
    // output stream
    output logic                          o_m_axis_tvalid,
    input  wire logic                     i_m_axis_tready,
    output logic      [TDATA_W-1:0]       o_m_axis_tdata   // mixed_i, mixed_q
);

    localparam int IDX_BITS = TABLE_ADDR_BITS + 2;
    localparam int PROD_W   = 2 * SAMPLE_BITS;
    localparam int SUM_W    = PROD_W + 1;
    localparam int FRAC     = SAMPLE_BITS - 1;
    localparam int SHR_W    = SUM_W - FRAC;

    typedef logic signed [SAMPLE_BITS-1:0] t_smp;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [SUM_W-1:0]       t_sum;

    // config registers
    logic [CFG_DATA_BITS-1:0] r_phase_inc;
    logic [CFG_DATA_BITS-1:0] r_start_phase;
    logic                     r_mix_dir;

    logic [PHASE_BITS-1:0]    r_phase_accum;
    logic [PHASE_BITS-1:0]    n_phase_accum;
    logic [PHASE_BITS-1:0]    phase_now;
    logic [63:0]              start_ext;
    logic [63:0]              inc_ext;

    // pipeline valids and enables
    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;
    logic in_accept;

    // stage 1
    t_smp                r_smp_i1, r_smp_q1;
    logic [MAG_BITS-1:0] sin_mag, cos_mag;
    t_fold               fold;
    t_smp                sin_val, cos_val;

    // stage 2
    t_prod r_ic, r_qs, r_is, r_qc;

    // stage 3
    t_sum                  sum_i, sum_q;
    logic [SAMPLE_BITS-1:0] res_i, res_q;
    logic [SAMPLE_BITS-1:0] r_mixed_i, r_mixed_q;

    function automatic t_smp fold_val(input logic [MAG_BITS-1:0] mag,
                                      input logic is_max, input logic is_neg);
        t_smp v;
        v = is_max ? t_smp'({1'b0, AMP}) : t_smp'({1'b0, mag});
        return is_neg ? t_smp'(-v) : v;
    endfunction

    // round half up, then clamp to the sample range
    function automatic logic [SAMPLE_BITS-1:0] round_sat(input t_sum v);
        t_sum              r;
        logic signed [SHR_W-1:0] s;
        logic [SAMPLE_BITS-1:0]  res;
        r = v + t_sum'(1 <<< (FRAC - 1));
        s = SHR_W'(r >>> FRAC);
        if (s > SHR_W'(signed'({1'b0, {FRAC{1'b1}}}))) begin
            res = {1'b0, {FRAC{1'b1}}};
        end else if (s < -SHR_W'(signed'({1'b0, 1'b1, {FRAC{1'b0}}}))) begin
            res = {1'b1, {FRAC{1'b0}}};
        end else begin
            res = s[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

    assign rdy3      = !r_v3 || i_m_axis_tready;
    assign rdy2      = !r_v2 || rdy3;
    assign rdy1      = !r_v1 || rdy2;
    assign in_accept = i_s_axis_tvalid && rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc   <= '0;
            r_start_phase <= '0;
            r_mix_dir     <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_PHASE_INC:   r_phase_inc   <= i_cfg_wdata;
                CFG_START_PHASE: r_start_phase <= i_cfg_wdata;
                CFG_MIX_DIR:     r_mix_dir     <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // restart loads the start phase for this item; the increment follows it
    always_comb begin
        start_ext     = {32'd0, r_start_phase};
        inc_ext       = {{32{r_phase_inc[31]}}, r_phase_inc};
        phase_now     = i_s_axis_tuser[0] ? start_ext[PHASE_BITS-1:0] : r_phase_accum;
        n_phase_accum = phase_now + inc_ext[PHASE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_accum <= '0;
        end else if (in_accept) begin
            r_phase_accum <= n_phase_accum;
        end
    end

    ncomix_sincos #(
        .ADDR_BITS  (TABLE_ADDR_BITS)
    ) u_sincos (
        .i_clk       (i_clk),
        .i_en        (rdy1),
        .i_phase_idx (phase_now[PHASE_BITS-1 -: IDX_BITS]),
        .o_sin_mag   (sin_mag),
        .o_cos_mag   (cos_mag),
        .o_fold      (fold)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= in_accept;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_smp_i1 <= t_smp'(i_s_axis_tdata[SAMPLE_BITS-1:0]);
            r_smp_q1 <= t_smp'(i_s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
        end
    end

    always_comb begin
        sin_val = fold_val(sin_mag, fold.sin_max, fold.sin_neg);
        cos_val = fold_val(cos_mag, fold.cos_max, fold.cos_neg);
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_ic <= t_prod'(r_smp_i1) * t_prod'(cos_val);
            r_qs <= t_prod'(r_smp_q1) * t_prod'(sin_val);
            r_is <= t_prod'(r_smp_i1) * t_prod'(sin_val);
            r_qc <= t_prod'(r_smp_q1) * t_prod'(cos_val);
        end
    end

    always_comb begin
        if (r_mix_dir) begin
            sum_i = t_sum'(r_ic) + t_sum'(r_qs);
            sum_q = t_sum'(r_qc) - t_sum'(r_is);
        end else begin
            sum_i = t_sum'(r_ic) - t_sum'(r_qs);
            sum_q = t_sum'(r_is) + t_sum'(r_qc);
        end
        res_i = round_sat(sum_i);
        res_q = round_sat(sum_q);
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_mixed_i <= res_i;
            r_mixed_q <= res_q;
        end
    end

    assign o_s_axis_tready = rdy1;
    assign o_m_axis_tvalid = r_v3;
    assign o_m_axis_tdata  = TDATA_W'({r_mixed_q, r_mixed_i});

endmodule

`default_nettype wire

[rtl/ncomix_checker.sv]
`default_nettype none

module ncomix_checker
    import ncomix_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  wire logic                     i_s_axis_tvalid,
    input  wire logic                     o_s_axis_tready,
    input  wire logic [TDATA_W-1:0]       i_s_axis_tdata,
    input  wire logic [0:0]               i_s_axis_tuser,
    input  wire logic                     o_m_axis_tvalid,
    input  wire logic                     i_m_axis_tready,
    input  wire logic [TDATA_W-1:0]       o_m_axis_tdata
);

    logic s_acc;
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    // stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output item changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // empty output register means the whole pipe can advance
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input not ready with empty output");

    // with no back-pressure an accepted item reaches the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc ##1 i_m_axis_tready ##1 i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("accepted item did not reach the output");

    // config writes and payload are not checked here
    logic unused_ok;
    assign unused_ok = i_cfg_we ^ (^i_cfg_addr) ^ (^i_cfg_wdata) ^ (^i_s_axis_tdata)
                       ^ i_s_axis_tuser[0];

endmodule

bind nco_complex_mixer_unit ncomix_checker u_ncomix_checker (.*);

`default_nettype wire

[bench/nco_complex_mixer_unit_test.sv]
`timescale 1ns / 100ps

module nco_complex_mixer_unit_test;
    import ncomix_pkg::*;

    localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 1100;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        logic [CFG_ADDR_BITS-1:0] reg_addr;
        logic [CFG_DATA_BITS-1:0] wdata;
        logic [15:0]              si;
        logic [15:0]              sq;
        logic                     restart;
        logic                     typed;
        logic [15:0]              ei;
        logic [15:0]              eq;
    } t_row;

    typedef struct packed {
        logic signed [15:0] mi;
        logic signed [15:0] mq;
    } t_mixed;

    // typed rows: full-scale values at phase 0 and at 45 degrees
    localparam t_row DIRECTED_ROWS [0:25] = '{
        '{ROW_SAMPLE, 2'd0, 32'd0, 16'h7FFF, 16'h0000, 1'b0, 1'b1, 16'h7FFE, 16'h0000},
        '{ROW_SAMPLE, 2'd0, 32'd0, 16'h8000, 16'h0000, 1'b0, 1'b1, 16'h8001, 16'h0000},
        '{ROW_SAMPLE, 2'd0, 32'd0, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'h0000, 16'h0000},
        '{ROW_SAMPLE, 2'd0, 32'd0, 16'h0000, 16'h8000, 1'b0, 1'b1, 16'h0000, 16'h8001},
        '{ROW_WRITE, CFG_START_PHASE, 32'h2000_0000, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_SAMPLE, 2'd0, 32'd0, 16'h8000, 16'h8000, 1'b1, 1'b1, 16'h0000, 16'h8000},
        '{ROW_SAMPLE, 2'd0, 32'd0, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 16'h0000, 16'h7FFF},
        '{ROW_WRITE, CFG_MIX_DIR, 32'h0000_0001, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_SAMPLE, 2'd0, 32'd0, 16'h8000, 16'h8000, 1'b1, 1'b1, 16'h8000, 16'h0000},
        // upper bits of the direction write are dropped, so this mixes up again
        '{ROW_WRITE, CFG_MIX_DIR, 32'hFFFF_FFFE, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_SAMPLE, 2'd0, 32'd0, 16'h8000, 16'h8000, 1'b1, 1'b1, 16'h0000, 16'h8000},
        // write to an unmapped index must not touch any register
        '{ROW_WRITE, REG_SPARE, 32'hFFFF_FFFF, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_SAMPLE, 2'd0, 32'd0, 16'h8000, 16'h8000, 1'b1, 1'b1, 16'h0000, 16'h8000},
        '{ROW_WRITE, CFG_PHASE_INC, 32'h7FFF_FFFF, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_WRITE, CFG_START_PHASE, 32'hFFFF_FFFF, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_SAMPLE, 2'd0, 32'd0, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 16'h0, 16'h0},
        '{ROW_SAMPLE, 2'd0, 32'd0, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_SAMPLE, 2'd0, 32'd0, 16'h5A5A, 16'hA5A5, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_SAMPLE, 2'd0, 32'd0, 16'hFFFF, 16'h0001, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_WRITE, CFG_PHASE_INC, 32'h8000_0000, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_WRITE, CFG_MIX_DIR, 32'h0000_0001, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_SAMPLE, 2'd0, 32'd0, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_SAMPLE, 2'd0, 32'd0, 16'h0001, 16'hFFFF, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_WRITE, CFG_PHASE_INC, 32'h0000_0001, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_SAMPLE, 2'd0, 32'd0, 16'h8000, 16'h7FFF, 1'b1, 1'b0, 16'h0, 16'h0},
        '{ROW_SAMPLE, 2'd0, 32'd0, 16'h1234, 16'hEDCB, 1'b0, 1'b0, 16'h0, 16'h0}
    };

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [TDATA_W-1:0]       s_data = '0;
    logic [0:0]               s_restart = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [TDATA_W-1:0]       m_data;

    nco_complex_mixer_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),     // sample_i, sample_q
        .i_s_axis_tuser  (s_restart),  // restart
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)      // mixed_i, mixed_q
    );

    // mixer model state
    int          sine_quarter [0:1023];
    logic [31:0] nco_phase_inc = '0;
    logic [31:0] nco_start_phase = '0;
    logic        nco_mix_down = 1'b0;
    logic [31:0] nco_phase = '0;
    t_mixed      mixed_due [$];
    int          fail_count = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // quarter-wave sine, Taylor series in Q2.30 scaled to full scale
    function automatic void build_sine_quarter();
        bit [63:0] x;
        bit [63:0] x2;
        bit [63:0] t;
        longint    sum;
        for (int k = 0; k < 1024; k++) begin
            x = (HPI_Q30 * 64'(k) + 64'd512) >> 10;
            x2 = (x * x) >> 30;
            t = x;
            sum = longint'(x);
            for (int n = 1; n <= 6; n++) begin
                t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum = sum - longint'(t);
                end else begin
                    sum = sum + longint'(t);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            sine_quarter[k] = int'((64'(sum) * 64'(AMP) + (64'd1 << 29)) >> 30);
        end
    endfunction

    // n is the top 12 phase bits: quadrant then offset
    function automatic longint sine_at(input logic [11:0] n);
        logic [9:0] a;
        logic [9:0] mirror;
        longint     v;
        a = n[9:0];
        mirror = ~a + 10'd1;
        if (n[10]) begin
            v = (a == 10'd0) ? longint'(AMP) : longint'(sine_quarter[mirror]);
        end else begin
            v = longint'(sine_quarter[a]);
        end
        return n[11] ? -v : v;
    endfunction

    function automatic logic signed [15:0] round_clip(input longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 32767) begin
            r = 32767;
        end
        if (r < -32768) begin
            r = -32768;
        end
        return 16'(r);
    endfunction

    function automatic t_mixed rotate_sample(input logic signed [15:0] si,
                                             input logic signed [15:0] sq,
                                             input logic restart);
        logic [11:0] n;
        longint      s;
        longint      c;
        longint      ri;
        longint      rq;
        t_mixed      res;
        if (restart) begin
            nco_phase = nco_start_phase;
        end
        n = nco_phase[31:20];
        s = sine_at(n);
        c = sine_at(n + 12'd1024);
        if (nco_mix_down) begin
            ri = longint'(si) * c + longint'(sq) * s;
            rq = longint'(sq) * c - longint'(si) * s;
        end else begin
            ri = longint'(si) * c - longint'(sq) * s;
            rq = longint'(si) * s + longint'(sq) * c;
        end
        res.mi = round_clip(ri);
        res.mq = round_clip(rq);
        nco_phase = nco_phase + nco_phase_inc;
        return res;
    endfunction

    // returns at the accepting edge with valid still high
    task automatic push_sample(input logic [15:0] si, input logic [15:0] sq,
                               input logic restart, input logic typed,
                               input logic [15:0] ei, input logic [15:0] eq);
        t_mixed res;
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_data <= {sq, si};
        s_restart <= restart;
        do @(posedge i_clk); while (!s_ready);
        res = rotate_sample(si, sq, restart);
        if (typed) begin
            res.mi = ei;
            res.mq = eq;
        end
        mixed_due.push_back(res);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            s_valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_for_empty();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (mixed_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [CFG_DATA_BITS-1:0] data);
        wait_for_empty();
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (addr)
            CFG_PHASE_INC:   nco_phase_inc = data;
            CFG_START_PHASE: nco_start_phase = data;
            CFG_MIX_DIR:     nco_mix_down = data[0];
            default: ;
        endcase
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_increment();
        logic [31:0] mag;
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: begin
                mag = $urandom_range(1, 1 << 22);
                return $urandom_range(0, 1) ? -mag : mag;
            end
            2: return 32'($urandom_range(0, 4095)) << 20;
            3: return 32'h0;
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    // output side stall patterns, switched at random
    logic [1:0] ready_mode = 2'd0;
    int         mode_left = 0;
    int         stall_left = 0;
    logic [7:0] ready_walk = 8'b1011_0110;

    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode <= 2'($urandom_range(0, 3));
            mode_left <= $urandom_range(40, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        ready_walk <= {ready_walk[6:0], ready_walk[7]};
        case (ready_mode)
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= ($urandom_range(0, 3) != 0);
            2'd2: m_ready <= ready_walk[0];
            default: begin
                if (stall_left != 0) begin
                    m_ready <= 1'b0;
                    stall_left <= stall_left - 1;
                end else if ($urandom_range(0, 7) == 0) begin
                    m_ready <= 1'b0;
                    stall_left <= $urandom_range(1, 15);
                end else begin
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin : check_mixed
        t_mixed due;
        logic signed [15:0] got_i;
        logic signed [15:0] got_q;
        if (i_rst_n && m_valid && m_ready) begin
            got_i = m_data[15:0];
            got_q = m_data[31:16];
            if (mixed_due.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected item, actual mixed_i %0d mixed_q %0d",
                         $time, got_i, got_q);
            end else begin
                due = mixed_due.pop_front();
                if (got_i !== due.mi) begin
                    fail_count++;
                    $display("%0t: mixed_i expected %0d actual %0d", $time, due.mi, got_i);
                end
                if (got_q !== due.mq) begin
                    fail_count++;
                    $display("%0t: mixed_q expected %0d actual %0d", $time, due.mq, got_q);
                end
            end
        end
    end

    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("nco_complex_mixer_unit_test failed");
            $finish;
        end
    end

    initial begin
        t_row        row;
        int          sent;
        int          phase_idx;
        int          phase_len;
        int          burst_left;
        logic [31:0] inc_val;
        logic [31:0] start_val;
        logic        restart;
        build_sine_quarter();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[r]) begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_WRITE) begin
                write_reg(row.reg_addr, row.wdata);
            end else begin
                push_sample(row.si, row.sq, row.restart, row.typed, row.ei, row.eq);
                idle_gap($urandom_range(0, 2));
            end
        end

        sent = 0;
        phase_idx = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase_idx)
                0: begin inc_val = 32'h7FFF_FFFF; start_val = 32'h0; end
                1: begin inc_val = 32'h8000_0000; start_val = 32'hFFFF_FFFF; end
                2: begin inc_val = 32'hFFFF_FFFF; start_val = $urandom; end
                default: begin inc_val = pick_increment(); start_val = $urandom; end
            endcase
            write_reg(CFG_PHASE_INC, inc_val);
            write_reg(CFG_START_PHASE, start_val);
            write_reg(CFG_MIX_DIR, (phase_idx < 2) ? 32'(phase_idx) : $urandom);
            phase_len = $urandom_range(60, 160);
            burst_left = 0;
            for (int k = 0; k < phase_len; k++) begin
                if (burst_left == 0) begin
                    // long bursts now and then keep the input busy with no idling
                    burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
                    if ($urandom_range(0, 3) != 0) begin
                        idle_gap($urandom_range(1, 12));
                    end
                end
                burst_left--;
                if ($urandom_range(0, 99) == 0) begin
                    wait_for_empty();
                end
                restart = (k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 19) == 0);
                push_sample(pick_sample(), pick_sample(), restart, 1'b0, 16'h0, 16'h0);
                sent++;
            end
            phase_idx++;
        end

        wait_for_empty();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("nco_complex_mixer_unit_test passed");
        end else begin
            $display("nco_complex_mixer_unit_test failed");
        end
        $finish;
    end

endmodule
